// File: sv/axr_pkg.sv
// Shared types and constants for the accelerometer remap, offset and low-pass block.
// No dependencies; the interfaces and the top level import it.
package axr_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned NUM_AX  = 3;
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned FRAC_W  = 30;

    typedef logic signed [DATA_W-1:0] t_s32;
    typedef logic [CFG_IDX_W-1:0]     t_cfg_idx;

    // register indexes of the configuration port
    localparam t_cfg_idx REG_COEF_PREV  = 8'd0;
    localparam t_cfg_idx REG_COEF_PREV2 = 8'd1;
    localparam t_cfg_idx REG_COEF_INPUT = 8'd2;
    localparam t_cfg_idx REG_OFFSET_X   = 8'd3;
    localparam t_cfg_idx REG_OFFSET_Y   = 8'd4;
    localparam t_cfg_idx REG_OFFSET_Z   = 8'd5;

    // Q2.30 coefficient reset values
    localparam t_s32 RST_COEF_PREV  = 32'sd2071735498;
    localparam t_s32 RST_COEF_PREV2 = -32'sd1000494912;
    localparam t_s32 RST_COEF_INPUT = 32'sd2501237;

endpackage

// File: sv/axr_if.sv
// Channel interfaces: raw sample input, calibrated/filtered result output, config writes.
// Depends on axr_pkg.
interface axr_in_if;
    import axr_pkg::*;
    logic valid;
    logic ready;
    t_s32 raw_x;
    t_s32 raw_y;
    t_s32 raw_z;
    logic data_ready;
    modport source (output valid, raw_x, raw_y, raw_z, data_ready, input ready);
    modport sink   (input valid, raw_x, raw_y, raw_z, data_ready, output ready);
endinterface

interface axr_out_if;
    import axr_pkg::*;
    logic valid;
    logic ready;
    t_s32 cal_x;
    t_s32 cal_y;
    t_s32 cal_z;
    t_s32 filt_x;
    t_s32 filt_y;
    t_s32 filt_z;
    modport source (output valid, cal_x, cal_y, cal_z, filt_x, filt_y, filt_z, input ready);
    modport sink   (input valid, cal_x, cal_y, cal_z, filt_x, filt_y, filt_z, output ready);
endinterface

interface axr_cfg_if;
    import axr_pkg::*;
    logic     valid;
    logic     ready;
    t_cfg_idx index;
    t_s32     data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/accel_axis_remap_offset_iir_lowpass_unit.sv
// Top level: axis remap, offset add and second-order IIR low-pass on three axes.
// Depends on axr_pkg and the interfaces in axr_if.sv.
//
//  channel  | dir | payload                                  | request accepted when
//  ---------+-----+------------------------------------------+------------------------
//  i_in     | in  | raw_x, raw_y, raw_z, data_ready          | valid & ready
//  o_res    | out | cal_x/y/z, filt_x/y/z                    | valid & ready
//  i_cfg    | in  | index, data (register write)             | valid & ready (always ready)
//
// Two register stages: an input register, then the result register. One request
// per cycle sustained while the receiver takes each result; an accepted request
// moves through the input register into the result register, which drives result valid.
// Filter taps update as a request with data_ready set moves from the input register to
// the result register, so the next request already sees them. A stalled result holds the
// result register and, once the input register is full too, drops i_in.ready.
// Synchronous active-low reset restores coefficients, zeroes offsets and taps.
module accel_axis_remap_offset_iir_lowpass_unit (
    input  logic i_clk,
    input  logic i_rst_n,
    axr_in_if.sink    i_in,
    axr_out_if.source o_res,
    axr_cfg_if.sink   i_cfg
);
    import axr_pkg::*;

    localparam int unsigned ACC_W = 2 * DATA_W + 2;
    localparam int unsigned RND_W = ACC_W - FRAC_W;

    // configuration
    t_s32 r_coef_prev, r_coef_prev2, r_coef_input;
    t_s32 r_offset [NUM_AX];

    // filter state
    t_s32 r_last  [NUM_AX];
    t_s32 r_older [NUM_AX];
    logic r_primed;

    // input register
    logic r_in_valid;
    t_s32 r_raw [NUM_AX];
    logic r_rdy;

    // result register
    logic r_out_valid;
    t_s32 r_cal  [NUM_AX];
    t_s32 r_filt [NUM_AX];

    logic advance;
    t_s32 n_cal   [NUM_AX];
    t_s32 n_last  [NUM_AX];
    t_s32 n_older [NUM_AX];
    t_s32 filt_y  [NUM_AX];
    logic signed [DATA_W:0] remap [NUM_AX];

    function automatic t_s32 sat_add(input logic signed [DATA_W:0] v);
        if (v[DATA_W] != v[DATA_W-1]) begin
            return v[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end
        return v[DATA_W-1:0];
    endfunction

    function automatic t_s32 sat_rnd(input logic signed [RND_W-1:0] v);
        if (v[RND_W-1:DATA_W-1] != {(RND_W-DATA_W+1){v[RND_W-1]}}) begin
            return v[RND_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end
        return v[DATA_W-1:0];
    endfunction

    // exact sum of three Q2.30 products, round half up, keep Q16.16
    function automatic t_s32 iir_step(input t_s32 c0, input t_s32 x0,
                                      input t_s32 c1, input t_s32 x1,
                                      input t_s32 c2, input t_s32 x2);
        logic signed [2*DATA_W-1:0] p0, p1, p2;
        logic signed [ACC_W-1:0]    acc;
        p0  = c0 * x0;
        p1  = c1 * x1;
        p2  = c2 * x2;
        acc = {{2{p0[2*DATA_W-1]}}, p0} + {{2{p1[2*DATA_W-1]}}, p1}
            + {{2{p2[2*DATA_W-1]}}, p2} + (ACC_W'(1) <<< (FRAC_W - 1));
        return sat_rnd(acc[ACC_W-1:FRAC_W]);
    endfunction

    assign advance     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_in.ready  = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;

    always_comb begin
        // x from y, y from minus x, z from z
        remap[0] = {r_raw[1][DATA_W-1], r_raw[1]};
        remap[1] = -{r_raw[0][DATA_W-1], r_raw[0]};
        remap[2] = {r_raw[2][DATA_W-1], r_raw[2]};
        for (int a = 0; a < NUM_AX; a++) begin
            n_cal[a]  = sat_add(remap[a] + {r_offset[a][DATA_W-1], r_offset[a]});
            filt_y[a] = iir_step(r_coef_prev, r_last[a], r_coef_prev2, r_older[a],
                                 r_coef_input, n_cal[a]);
            n_last[a]  = r_last[a];
            n_older[a] = r_older[a];
            if (r_rdy) begin
                if (!r_primed) begin
                    n_last[a]  = n_cal[a];
                    n_older[a] = n_cal[a];
                end else begin
                    n_last[a]  = filt_y[a];
                    n_older[a] = r_last[a];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_prev  <= RST_COEF_PREV;
            r_coef_prev2 <= RST_COEF_PREV2;
            r_coef_input <= RST_COEF_INPUT;
            for (int a = 0; a < NUM_AX; a++) begin
                r_offset[a] <= '0;
            end
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_COEF_PREV:  r_coef_prev  <= i_cfg.data;
                REG_COEF_PREV2: r_coef_prev2 <= i_cfg.data;
                REG_COEF_INPUT: r_coef_input <= i_cfg.data;
                REG_OFFSET_X:   r_offset[0]  <= i_cfg.data;
                REG_OFFSET_Y:   r_offset[1]  <= i_cfg.data;
                REG_OFFSET_Z:   r_offset[2]  <= i_cfg.data;
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_primed    <= 1'b0;
            for (int a = 0; a < NUM_AX; a++) begin
                r_last[a]  <= '0;
                r_older[a] <= '0;
            end
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_primed    <= r_primed || r_rdy;
                for (int a = 0; a < NUM_AX; a++) begin
                    r_last[a]  <= n_last[a];
                    r_older[a] <= n_older[a];
                end
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_raw[0] <= i_in.raw_x;
            r_raw[1] <= i_in.raw_y;
            r_raw[2] <= i_in.raw_z;
            r_rdy    <= i_in.data_ready;
        end
        if (advance) begin
            for (int a = 0; a < NUM_AX; a++) begin
                r_cal[a]  <= n_cal[a];
                r_filt[a] <= n_last[a];
            end
        end
    end

    assign o_res.valid  = r_out_valid;
    assign o_res.cal_x  = r_cal[0];
    assign o_res.cal_y  = r_cal[1];
    assign o_res.cal_z  = r_cal[2];
    assign o_res.filt_x = r_filt[0];
    assign o_res.filt_y = r_filt[1];
    assign o_res.filt_z = r_filt[2];

endmodule

// File: tb/tb.sv
// Self-checking bench for the accelerometer remap, offset and low-pass unit.
// Depends on axr_pkg and the channel interfaces in axr_if.sv; predicts every result
// in place and checks it against the unit under random valid/ready pressure.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import axr_pkg::*;

    localparam int unsigned QUIET_LIMIT = 4000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned TAIL_CYCLES = 8;
    localparam t_cfg_idx    REG_UNUSED  = 8'hFF;
    localparam t_s32        S32_MAX     = 32'sh7FFFFFFF;
    localparam t_s32        S32_MIN     = 32'sh80000000;

    typedef struct {
        t_s32 raw_x;
        t_s32 raw_y;
        t_s32 raw_z;
        logic data_ready;
    } t_sample;

    typedef struct {
        t_s32 cal[NUM_AX];
        t_s32 filt[NUM_AX];
    } t_accel_res;

    logic i_clk;
    logic i_rst_n;

    axr_in_if  in_ch ();
    axr_out_if res_ch ();
    axr_cfg_if cfg_ch ();

    accel_axis_remap_offset_iir_lowpass_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    // predictor copy of registers and filter taps
    t_s32 coef_prev;
    t_s32 coef_prev2;
    t_s32 coef_input;
    t_s32 offset [NUM_AX];
    t_s32 tap_last [NUM_AX];
    t_s32 tap_older [NUM_AX];
    logic taps_primed;

    t_sample    sample_q[$];
    t_accel_res cal_filt_q[$];

    logic idle_en;
    logic pressure_go;
    logic rx_holdoff;
    int   tx_gap;
    int   rx_stall;
    int   quiet_cycles;
    int   mismatches;
    int   failures;
    int   n_samples;
    int   n_fresh;
    int   n_results;
    int   n_writes;
    int   n_settings;

    string fld_names [2*NUM_AX] = '{"cal_x", "cal_y", "cal_z", "filt_x", "filt_y", "filt_z"};

    function automatic t_s32 clamp_s32(logic signed [66:0] v);
        if (v > S32_MAX)
            return S32_MAX;
        if (v < S32_MIN)
            return S32_MIN;
        return t_s32'(v);
    endfunction

    function automatic t_s32 rand_span(int unsigned half);
        return t_s32'($urandom_range(0, 2 * half)) - t_s32'(half);
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_en || r < 70)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic t_s32 rand_raw();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return S32_MAX;
        if (r == 1)
            return S32_MIN;
        if (r < 5)
            return t_s32'($urandom);
        return rand_span(32'h0010_0000);
    endfunction

    // remap, offset and filter one request; updates the taps when data_ready is set
    function automatic t_accel_res calibrate_and_filter(t_sample s);
        t_accel_res res;
        logic signed [66:0] acc;
        res.cal[0] = clamp_s32(longint'(s.raw_y) + longint'(offset[0]));
        res.cal[1] = clamp_s32(-longint'(s.raw_x) + longint'(offset[1]));
        res.cal[2] = clamp_s32(longint'(s.raw_z) + longint'(offset[2]));
        if (s.data_ready) begin
            n_fresh++;
            for (int a = 0; a < NUM_AX; a++) begin
                if (!taps_primed) begin
                    tap_last[a]  = res.cal[a];
                    tap_older[a] = res.cal[a];
                end else begin
                    acc = coef_prev * tap_last[a] + coef_prev2 * tap_older[a]
                        + coef_input * res.cal[a] + (67'sd1 <<< (FRAC_W - 1));
                    tap_older[a] = tap_last[a];
                    tap_last[a]  = clamp_s32(acc >>> FRAC_W);
                end
            end
            taps_primed = 1'b1;
        end
        for (int a = 0; a < NUM_AX; a++)
            res.filt[a] = tap_last[a];
        return res;
    endfunction

    function automatic void queue_sample(t_s32 x, t_s32 y, t_s32 z, logic dr);
        t_sample s;
        s.raw_x      = x;
        s.raw_y      = y;
        s.raw_z      = z;
        s.data_ready = dr;
        sample_q.push_back(s);
    endfunction

    task automatic write_reg(t_cfg_idx idx, t_s32 val);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge i_clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        n_writes++;
        case (idx)
            REG_COEF_PREV:  coef_prev  = val;
            REG_COEF_PREV2: coef_prev2 = val;
            REG_COEF_INPUT: coef_input = val;
            REG_OFFSET_X:   offset[0]  = val;
            REG_OFFSET_Y:   offset[1]  = val;
            REG_OFFSET_Z:   offset[2]  = val;
            default: ;
        endcase
    endtask

    task automatic set_config(t_s32 cp, t_s32 cp2, t_s32 ci, t_s32 ox, t_s32 oy, t_s32 oz);
        write_reg(REG_COEF_PREV, cp);
        write_reg(REG_COEF_PREV2, cp2);
        write_reg(REG_COEF_INPUT, ci);
        write_reg(REG_OFFSET_X, ox);
        write_reg(REG_OFFSET_Y, oy);
        write_reg(REG_OFFSET_Z, oz);
        n_settings++;
    endtask

    // hold until every queued request has been answered and the pipe is empty
    task automatic wait_drained();
        while (sample_q.size() != 0 || cal_filt_q.size() != 0 || in_ch.valid)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // request driver
    always @(posedge i_clk) begin : sample_driver
        t_accel_res want;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                want = calibrate_and_filter(sample_q[0]);
                cal_filt_q.push_back(want);
                sample_q.pop_front();
                n_samples++;
                tx_gap = pick_gap();
            end
            if (in_ch.valid && !in_ch.ready) begin
                // hold the offered request
            end else if (tx_gap > 0) begin
                tx_gap--;
                in_ch.valid <= 1'b0;
            end else if (sample_q.size() != 0) begin
                in_ch.valid      <= 1'b1;
                in_ch.raw_x      <= sample_q[0].raw_x;
                in_ch.raw_y      <= sample_q[0].raw_y;
                in_ch.raw_z      <= sample_q[0].raw_z;
                in_ch.data_ready <= sample_q[0].data_ready;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // result monitor and receiver back-pressure
    always @(posedge i_clk) begin : result_monitor
        t_accel_res got;
        t_accel_res want;
        t_s32 g;
        t_s32 w;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                n_results++;
                got.cal[0]  = res_ch.cal_x;
                got.cal[1]  = res_ch.cal_y;
                got.cal[2]  = res_ch.cal_z;
                got.filt[0] = res_ch.filt_x;
                got.filt[1] = res_ch.filt_y;
                got.filt[2] = res_ch.filt_z;
                if (cal_filt_q.size() == 0) begin
                    failures++;
                    $display("ERROR: result with nothing pending at %0t", $realtime);
                end else begin
                    want = cal_filt_q.pop_front();
                    for (int f = 0; f < 2 * NUM_AX; f++) begin
                        g = (f < NUM_AX) ? got.cal[f] : got.filt[f - NUM_AX];
                        w = (f < NUM_AX) ? want.cal[f] : want.filt[f - NUM_AX];
                        if (g !== w) begin
                            mismatches++;
                            failures++;
                            if (mismatches <= 10)
                                $display("MISMATCH result %0d %s: expected %0d (%h) got %0d (%h)",
                                         n_results, fld_names[f], w, w, g, g);
                        end
                    end
                end
            end
            if (rx_holdoff) begin
                res_ch.ready <= 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
                rx_stall = pick_gap();
            end
        end
    end

    // long receiver hold-off so the unit fills and drops its input ready
    initial begin : receiver_holdoff
        rx_holdoff = 1'b0;
        wait (pressure_go);
        @(posedge i_clk);
        rx_holdoff <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_holdoff <= 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", quiet_cycles);
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int k;
        int r;
        t_s32 cp;
        t_s32 cp2;
        t_s32 ci;
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.raw_x      = '0;
        in_ch.raw_y      = '0;
        in_ch.raw_z      = '0;
        in_ch.data_ready = 1'b0;
        res_ch.ready     = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = '0;
        cfg_ch.data      = '0;
        idle_en          = 1'b1;
        pressure_go      = 1'b0;
        tx_gap           = 0;
        rx_stall         = 0;
        quiet_cycles     = 0;
        mismatches       = 0;
        failures         = 0;
        n_samples        = 0;
        n_fresh          = 0;
        n_results        = 0;
        n_writes         = 0;
        n_settings       = 1;
        coef_prev        = RST_COEF_PREV;
        coef_prev2       = RST_COEF_PREV2;
        coef_input       = RST_COEF_INPUT;
        taps_primed      = 1'b0;
        for (int a = 0; a < NUM_AX; a++) begin
            offset[a]    = '0;
            tap_last[a]  = '0;
            tap_older[a] = '0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: stale requests before priming, priming, then the filter
        queue_sample(32'sd100, -32'sd200, 32'sd300, 1'b0);
        queue_sample(S32_MAX, S32_MAX, S32_MAX, 1'b0);
        queue_sample(32'sd65536, 32'sd131072, 32'sd642252, 1'b1);
        queue_sample(32'sd70000, 32'sd120000, 32'sd640000, 1'b1);
        queue_sample(-32'sd50000, 32'sd150000, 32'sd650000, 1'b1);
        queue_sample(32'sd1, -32'sd1, 32'sd0, 1'b1);
        queue_sample(32'sd0, 32'sd0, 32'sd0, 1'b0);
        queue_sample(S32_MIN, S32_MAX, S32_MIN, 1'b1);
        queue_sample(32'sd0, 32'sd0, 32'sd0, 1'b1);
        wait_drained();

        // all registers at the positive extreme: saturation upward
        set_config(S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX);
        queue_sample(S32_MAX, S32_MAX, S32_MAX, 1'b1);
        queue_sample(S32_MIN, S32_MIN, S32_MIN, 1'b1);
        queue_sample(32'sd0, 32'sd0, 32'sd0, 1'b0);
        queue_sample(S32_MAX, S32_MIN, S32_MAX, 1'b1);
        wait_drained();

        // all registers at the negative extreme, plus a write to an unused index
        set_config(S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN);
        write_reg(REG_UNUSED, 32'sh5A5A5A5A);
        queue_sample(S32_MIN, S32_MIN, S32_MIN, 1'b1);
        queue_sample(S32_MAX, S32_MAX, S32_MAX, 1'b1);
        queue_sample(rand_raw(), rand_raw(), rand_raw(), 1'b1);
        queue_sample(rand_raw(), rand_raw(), rand_raw(), 1'b0);
        wait_drained();

        for (k = 0; k < 8; k++) begin
            if (k == 0 || k == 4) begin
                set_config(RST_COEF_PREV, RST_COEF_PREV2, RST_COEF_INPUT,
                           rand_span(32'h0004_0000), rand_span(32'h0004_0000),
                           rand_span(32'h0004_0000));
            end else if (k % 2 == 1) begin
                set_config(t_s32'($urandom), t_s32'($urandom), t_s32'($urandom),
                           t_s32'($urandom), t_s32'($urandom), t_s32'($urandom));
            end else begin
                // coefficients below unity keep the loop away from the rails
                cp  = rand_span(32'h3FFF_FFFF);
                cp2 = rand_span(32'h1FFF_FFFF);
                ci  = rand_span(32'h0FFF_FFFF);
                set_config(cp, cp2, ci, rand_span(32'h0100_0000),
                           rand_span(32'h0100_0000), rand_span(32'h0100_0000));
            end
            idle_en = (k != 2);
            if (k == 3)
                pressure_go = 1'b1;
            for (int n = 0; n < 100; n++) begin
                r = $urandom_range(0, 99);
                queue_sample(rand_raw(), rand_raw(), rand_raw(), r < 80);
            end
            wait_drained();
        end

        if (cal_filt_q.size() != 0) begin
            failures += cal_filt_q.size();
            $display("ERROR: %0d results never arrived", cal_filt_q.size());
        end
        $display("Covered %0d samples (%0d fresh) under %0d register settings, %0d writes.",
                 n_samples, n_fresh, n_settings, n_writes);
        $display("Compared %0d results field by field, %0d field mismatches.",
                 n_results, mismatches);
        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: files.f
sv/axr_pkg.sv
sv/axr_if.sv
sv/accel_axis_remap_offset_iir_lowpass_unit.sv
tb/tb.sv
